>>> rtl/sliding_window_ones_estimator_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sliding window ones estimator
// Short forms for same-cycle and next-cycle implication checks.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_ONES_ESTIMATOR_TOP_MACROS_SVH
`define SLIDING_WINDOW_ONES_ESTIMATOR_TOP_MACROS_SVH

// antecedent implies consequent in the same cycle
`define SWOE_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define SWOE_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/swoe_pkg.sv
// ----------------------------------------------------------------------------
// swoe_pkg
// Shared types, constants and helpers of the sliding window ones estimator.
// ----------------------------------------------------------------------------
`default_nettype none

package swoe_pkg;

    localparam int unsigned TIME_W  = 32;
    localparam int unsigned LOG_W   = 5;
    localparam int unsigned FIELD_W = 17;

    typedef logic [TIME_W-1:0]  time_t;
    typedef logic [LOG_W-1:0]   log_t;
    typedef logic [FIELD_W-1:0] field_t;

    localparam log_t   LOG_MAX      = '1;
    localparam field_t EST_MAX      = '1;
    localparam field_t WINDOW_RESET = 17'd1024;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_MERGE
    } cell_op_t;

    // broadcast to every cell of the chain
    typedef struct packed {
        cell_op_t op;
        time_t    new_stamp;
        time_t    ref_time;
        field_t   thr;
    } cell_cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MERGE,
        ST_EXPIRE,
        ST_QUERY,
        ST_DONE
    } state_t;

    // acc + 2^e, saturated to EST_MAX
    function automatic field_t add_pow2_sat(field_t acc, log_t e);
        logic [FIELD_W:0] sum;
        sum = '0;
        if (e >= LOG_W'(FIELD_W))
        begin
            return EST_MAX;
        end
        sum = {1'b0, acc} + ({{FIELD_W{1'b0}}, 1'b1} << e);
        if (sum > {1'b0, EST_MAX})
        begin
            return EST_MAX;
        end
        return sum[FIELD_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> rtl/swoe_cell.sv
// ----------------------------------------------------------------------------
// swoe_cell
// One bucket slot of the chain: stamp and size log, neighbor shifts,
// local triple-match and age checks.
// ----------------------------------------------------------------------------
`default_nettype none

module swoe_cell #(
    parameter int unsigned POS   = 0,
    parameter int unsigned CNT_W = 6
) (
    input  logic                  clk,
    input  swoe_pkg::cell_cmd_t   cmd,
    input  logic [CNT_W-1:0]      merge_idx,
    input  swoe_pkg::time_t       prev_time,
    input  swoe_pkg::log_t        prev_log,
    input  swoe_pkg::time_t       next_time,
    input  swoe_pkg::log_t        next_log,
    input  swoe_pkg::log_t        next2_log,
    output swoe_pkg::time_t       cell_time,
    output swoe_pkg::log_t        cell_log,
    output logic                  trip,
    output logic                  aged
);
    import swoe_pkg::*;

    localparam logic [CNT_W:0] POS_V = (CNT_W+1)'(POS);

    time_t            time_reg, time_next;
    log_t             log_reg, log_next;
    time_t            age;
    logic [CNT_W:0]   merge_pos;

    assign age       = cmd.ref_time - time_reg;
    assign aged      = age >= {{(TIME_W-FIELD_W){1'b0}}, cmd.thr};
    assign trip      = (log_reg == next_log) && (next_log == next2_log);
    assign merge_pos = {1'b0, merge_idx} + (CNT_W+1)'(1);
    assign cell_time = time_reg;
    assign cell_log  = log_reg;

    always_comb
    begin
        time_next = time_reg;
        log_next  = log_reg;
        unique case (cmd.op)
            OP_INSERT:
            begin
                time_next = prev_time;
                log_next  = prev_log;
            end
            OP_MERGE:
            begin
                // slot after merge_idx doubles, later slots close the gap
                if (POS_V == merge_pos)
                begin
                    log_next = (log_reg == LOG_MAX) ? LOG_MAX : log_reg + LOG_W'(1);
                end
                else if (POS_V > merge_pos)
                begin
                    time_next = next_time;
                    log_next  = next_log;
                end
            end
            default:
            begin
                time_next = time_reg;
                log_next  = log_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        time_reg <= time_next;
        log_reg  <= log_next;
    end

endmodule

`default_nettype wire

>>> rtl/sliding_window_ones_estimator_top.sv
// ----------------------------------------------------------------------------
// sliding_window_ones_estimator_top
// Approximate count of ones over the recent part of a bit stream, kept as
// power-of-two buckets (exponential histogram) in a chain of bucket cells,
// newest bucket in cell 0.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-------------------------------
//   input    | in_valid / in_stall  | func, bit_in, query_len
//   output   | out_valid / out_stall| ones_estimate
//   config   | cfg_wr_en            | cfg_wr_data (window_size)
//
// One transaction is worked on at a time; the sequencer walks the chain one
// bucket per cycle. Push of a zero: accept step, then the expiry walk. Push of
// a one: insert step, a merge scan over up to about BUCKET_SLOTS buckets, then
// the expiry walk. Query: accept step, the counting walk, then a result step.
// Reset empties the bucket store and clears the stream time; no clear pass.
// A stalled result holds the output register; only a finishing query waits.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_ones_estimator_top #(
    parameter int unsigned MAX_WINDOW   = 65536,
    parameter int unsigned BUCKET_SLOTS = 34
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // config
    input  logic                  cfg_wr_en,
    input  swoe_pkg::field_t      cfg_wr_data,
    // input transactions
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  func,
    input  logic                  bit_in,
    input  swoe_pkg::field_t      query_len,
    // result transactions
    output logic                  out_valid,
    input  logic                  out_stall,
    output swoe_pkg::field_t      ones_estimate
);
    import swoe_pkg::*;

`include "sliding_window_ones_estimator_top_macros.svh"

    localparam int unsigned IDX_W = $clog2(BUCKET_SLOTS);
    localparam int unsigned CNT_W = $clog2(BUCKET_SLOTS + 1);
    localparam logic [CNT_W-1:0] COUNT_MAX = CNT_W'(BUCKET_SLOTS);

    // control state
    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    time_t             tc_reg, tc_next;
    field_t            window_reg;
    logic              out_valid_reg, out_valid_next;

    // working registers
    logic [CNT_W-1:0]  idx_reg, idx_next;
    time_t             ref_reg, ref_next;
    field_t            thr_reg, thr_next;
    field_t            acc_reg, acc_next;
    log_t              last_log_reg, last_log_next;
    logic              any_reg, any_next;
    field_t            est_reg, est_next;

    // chain
    cell_cmd_t         cmd;
    time_t             cell_time [BUCKET_SLOTS];
    log_t              cell_log  [BUCKET_SLOTS];
    logic [BUCKET_SLOTS-1:0] trip_vec;
    logic [BUCKET_SLOTS-1:0] aged_vec;

    // decisions
    logic              accept;
    logic [IDX_W-1:0]  sel;
    logic [CNT_W-1:0]  cnt_m1;
    logic [IDX_W-1:0]  oldest_sel;
    logic              merge_live;
    logic              merge_hit;
    logic              expire_hit;
    logic              query_take;
    logic              out_free;
    field_t            eff_win;

    assign in_stall      = (state_reg != ST_IDLE);
    assign accept        = in_valid && !in_stall;
    assign sel           = idx_reg[IDX_W-1:0];
    assign cnt_m1        = count_reg - CNT_W'(1);
    assign oldest_sel    = cnt_m1[IDX_W-1:0];
    assign merge_live    = ({1'b0, idx_reg} + (CNT_W+1)'(2)) < {1'b0, count_reg};
    assign merge_hit     = merge_live && trip_vec[sel];
    assign expire_hit    = (count_reg != '0) && aged_vec[oldest_sel];
    assign query_take    = (idx_reg < count_reg) && !aged_vec[sel];
    assign out_free      = !out_valid_reg || !out_stall;
    assign out_valid     = out_valid_reg;
    assign ones_estimate = est_reg;

    // window beyond the supported span acts as the span
    assign eff_win = ({{(TIME_W-FIELD_W){1'b0}}, window_reg} > TIME_W'(MAX_WINDOW))
                   ? FIELD_W'(MAX_WINDOW) : window_reg;

    // ------------------------------------------------------------------
    // bucket chain
    // ------------------------------------------------------------------
    for (genvar j = 0; j < BUCKET_SLOTS; j++)
    begin : g_cell
        time_t prv_t;
        log_t  prv_l;
        time_t nx_t;
        log_t  nx_l;
        log_t  nx2_l;

        if (j == 0)
        begin : g_head
            assign prv_t = cmd.new_stamp;
            assign prv_l = '0;
        end
        else
        begin : g_body
            assign prv_t = cell_time[j-1];
            assign prv_l = cell_log[j-1];
        end

        // tail neighbors are never consulted: the count gates them
        if (j + 1 < BUCKET_SLOTS)
        begin : g_nx
            assign nx_t = cell_time[j+1];
            assign nx_l = cell_log[j+1];
        end
        else
        begin : g_nx_tail
            assign nx_t = cell_time[j];
            assign nx_l = cell_log[j];
        end

        if (j + 2 < BUCKET_SLOTS)
        begin : g_nx2
            assign nx2_l = cell_log[j+2];
        end
        else
        begin : g_nx2_tail
            assign nx2_l = cell_log[j];
        end

        swoe_cell #(
            .POS   (j),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk       (clk),
            .cmd       (cmd),
            .merge_idx (idx_reg),
            .prev_time (prv_t),
            .prev_log  (prv_l),
            .next_time (nx_t),
            .next_log  (nx_l),
            .next2_log (nx2_l),
            .cell_time (cell_time[j]),
            .cell_log  (cell_log[j]),
            .trip      (trip_vec[j]),
            .aged      (aged_vec[j])
        );
    end

    // ------------------------------------------------------------------
    // sequencer: next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (func)
                        state_next = ST_QUERY;
                    else if (bit_in)
                        state_next = ST_MERGE;
                    else
                        state_next = ST_EXPIRE;
                end
            end
            ST_MERGE:
            begin
                if (!merge_live)
                    state_next = ST_EXPIRE;
            end
            ST_EXPIRE:
            begin
                if (!expire_hit)
                    state_next = ST_IDLE;
            end
            ST_QUERY:
            begin
                if (!query_take)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // sequencer: chain commands and datapath
    // ------------------------------------------------------------------
    always_comb
    begin
        cmd.op         = OP_HOLD;
        cmd.new_stamp  = tc_reg;
        cmd.ref_time   = ref_reg;
        cmd.thr        = thr_reg;
        count_next     = count_reg;
        tc_next        = tc_reg;
        idx_next       = idx_reg;
        ref_next       = ref_reg;
        thr_next       = thr_reg;
        acc_next       = acc_reg;
        last_log_next  = last_log_reg;
        any_next       = any_reg;
        est_next       = est_reg;
        out_valid_next = out_valid_reg && out_stall;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    ref_next = tc_reg;
                    idx_next = '0;
                    acc_next = '0;
                    any_next = 1'b0;
                    if (!func)
                    begin
                        thr_next = eff_win;
                        tc_next  = tc_reg + TIME_W'(1);
                        if (bit_in)
                        begin
                            // full store: the oldest bucket falls off the tail
                            cmd.op     = OP_INSERT;
                            count_next = (count_reg == COUNT_MAX)
                                       ? COUNT_MAX : count_reg + CNT_W'(1);
                        end
                    end
                    else
                    begin
                        thr_next = query_len;
                    end
                end
            end
            ST_MERGE:
            begin
                if (merge_hit)
                begin
                    cmd.op     = OP_MERGE;
                    count_next = count_reg - CNT_W'(1);
                end
                else if (merge_live)
                begin
                    idx_next = idx_reg + CNT_W'(1);
                end
            end
            ST_EXPIRE:
            begin
                if (expire_hit)
                    count_next = count_reg - CNT_W'(1);
            end
            ST_QUERY:
            begin
                if (query_take)
                begin
                    // the previous bucket is added in full once an older
                    // one follows; the final (oldest) one only counts at half
                    if (any_reg)
                        acc_next = add_pow2_sat(acc_reg, last_log_reg);
                    last_log_next = cell_log[sel];
                    any_next      = 1'b1;
                    idx_next      = idx_reg + CNT_W'(1);
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (!any_reg)
                        est_next = '0;
                    else if (last_log_reg == '0)
                        est_next = acc_reg;
                    else
                        est_next = add_pow2_sat(acc_reg, last_log_reg - LOG_W'(1));
                end
            end
            default:
            begin
                cmd.op = OP_HOLD;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            tc_reg        <= '0;
            window_reg    <= WINDOW_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            tc_reg        <= tc_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
                window_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        ref_reg      <= ref_next;
        thr_reg      <= thr_next;
        acc_reg      <= acc_next;
        last_log_reg <= last_log_next;
        any_reg      <= any_next;
        est_reg      <= est_next;
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `SWOE_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_reg <= COUNT_MAX,
        "bucket count above slot total")
    `SWOE_ASSERT_NXT(a_busy_after_accept, clk, rst_n, accept, state_reg != ST_IDLE,
        "sequencer idle right after a transaction")
    `SWOE_ASSERT_NXT(a_merge_shrinks, clk, rst_n, (state_reg == ST_MERGE) && merge_hit,
        count_reg == $past(count_reg) - CNT_W'(1), "merge did not remove one bucket")
    `SWOE_ASSERT_NXT(a_push_ticks, clk, rst_n, accept && !func,
        tc_reg == $past(tc_reg) + TIME_W'(1), "stream time not advanced by push")

endmodule

`default_nettype wire
